### sv/plss_pkg.sv
// Shared types, register codes, reset values and the frame store address
// function for the parallel LED strip serializer. No dependencies.
`default_nettype none

package plss_pkg;

  // Defaults for the top level parameters
  localparam int LANES_DEF      = 8;
  localparam int MAX_PIXELS_DEF = 256;

  // Physical output lines and bytes per pixel slot in the store
  localparam int LINE_COUNT = 8;
  localparam int BYTES_MAX  = 4;

  localparam logic [2:0] BIT_LAST = 3'd7;
  localparam logic [2:0] BPP_RGB  = 3'd3;
  localparam logic [2:0] BPP_RGBW = 3'd4;

  // Input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_LANE_COUNT = 3'd0;
  localparam logic [2:0] REG_LED_COUNT  = 3'd1;
  localparam logic [2:0] REG_RGBW_MODE  = 3'd2;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd4;
  localparam logic [2:0] REG_GAP_LOW    = 3'd5;

  // Register reset values
  localparam logic [3:0] RST_LANE_COUNT = 4'd1;
  localparam logic [8:0] RST_LED_COUNT  = 9'd1;
  localparam logic       RST_RGBW_MODE  = 1'b0;
  localparam logic [7:0] RST_ZERO_HIGH  = 8'd15;
  localparam logic [8:0] RST_ONE_HIGH   = 9'd45;
  localparam logic [7:0] RST_GAP_LOW    = 8'd18;

  typedef struct packed {
    logic [3:0] lane_count;
    logic [8:0] led_count;
    logic       rgbw_mode;
    logic [7:0] zero_high_ticks;
    logic [8:0] one_high_ticks;
    logic [7:0] gap_low_ticks;
  } cfg_t;

  // Control handed to the lane byte fetcher
  typedef struct packed {
    logic       inval;
    logic       sending;
    logic [3:0] lanes;
    logic [8:0] leds;
    logic       rgbw;
    logic [8:0] pixel;
    logic [1:0] byte_pos;
  } fetch_ctl_t;

  typedef struct packed {
    logic [7:0] line_levels;
    logic       busy_res;
    logic       frame_done;
    logic       write_rejected;
  } res_t;

  // Strip-major store address: (lane * leds + pixel) * bytes_per_pixel + byte
  function automatic logic [15:0] store_index(input logic [4:0] lane,
                                              input logic [8:0] pixel,
                                              input logic [1:0] byte_sel,
                                              input logic [8:0] leds,
                                              input logic       rgbw);
    logic [13:0] row;
    logic [15:0] base;
    row  = 14'(lane * leds) + 14'(pixel);
    base = rgbw ? {row, 2'b00} : (16'(row) + {1'b0, row, 1'b0});
    return base + 16'(byte_sel);
  endfunction

endpackage

`default_nettype wire

### sv/plss_ram.sv
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module plss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/plss_fetch.sv
// Lane byte fetcher: reads the byte of the current pixel/byte position for
// every active strip from the frame store, one lane per cycle. Uses plss_pkg.
`default_nettype none

module plss_fetch #(
  parameter int LINES  = 8,
  parameter int ADDR_W = 13
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire plss_pkg::fetch_ctl_t      ctl,
  output logic                           rd_en,
  output logic      [ADDR_W-1:0]         rd_addr,
  input  wire logic [7:0]                rd_data,
  output logic      [LINES-1:0][7:0]     lane_bytes,
  output logic                           ready
);

  localparam int LN_W = (LINES > 1) ? $clog2(LINES) : 1;

  logic [3:0]      cnt;
  logic            pend;
  logic [LN_W-1:0] pend_lane;
  logic            issue;

  assign issue  = ctl.sending && !ctl.inval && !ready && (cnt < ctl.lanes);
  assign rd_en  = issue;
  assign rd_addr = ADDR_W'(plss_pkg::store_index({1'b0, cnt}, ctl.pixel, ctl.byte_pos,
                                                 ctl.leds, ctl.rgbw));

  always_ff @(posedge clk) begin
    if (rst || ctl.inval) begin
      cnt   <= '0;
      pend  <= 1'b0;
      ready <= 1'b0;
    end else begin
      pend <= issue;
      if (issue) begin
        cnt <= cnt + 4'd1;
      end
      // all lanes issued and the last one captured
      if (ctl.sending && !ready && !issue && !pend) begin
        ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_lane <= cnt[LN_W-1:0];
    end
    if (pend) begin
      lane_bytes[pend_lane] <= rd_data;
    end
  end

endmodule

`default_nettype wire

### sv/parallel_led_strip_serializer.sv
// Top level of the parallel LED strip serializer: command decode, waveform
// timing, output skid stage. Uses plss_pkg, plss_ram and plss_fetch.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tuser kind, s_tdata lane/pixel/byte_sel/data
//   m_*      out  m_tvalid/m_tready  m_tdata line_levels/busy_res/write_rejected,
//                                    m_tlast frame_done
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One input beat per cycle while s_tready is high gives one result beat.
// Result beats are registered. The input stalls at the start of a byte while
// the strip bytes for it are read from the frame store, one lane per cycle
// through the RAM read port, after a start, a byte advance or a register write.
// Reset is synchronous; the frame store has no reset and needs no clearing.
// A two entry output stage takes one more input beat while m_tready is low.
`default_nettype none

module parallel_led_strip_serializer #(
  parameter int LANES      = plss_pkg::LANES_DEF,
  parameter int MAX_PIXELS = plss_pkg::MAX_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // lane[2:0], pixel[10:3], byte_sel[12:11], data[20:13]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // line_levels[7:0], busy_res[8], write_rejected[9]
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int LINES   = (LANES < plss_pkg::LINE_COUNT) ? LANES : plss_pkg::LINE_COUNT;
  localparam int DEPTH   = LANES * MAX_PIXELS * plss_pkg::BYTES_MAX;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int POS_MAX = (MAX_PIXELS < 511) ? MAX_PIXELS : 511;
  localparam int PIX_W   = (POS_MAX > 1) ? $clog2(POS_MAX) : 1;

  plss_pkg::cfg_t cfg;

  logic             sending;
  logic [PIX_W-1:0] pixel_pos;
  logic [1:0]       byte_pos;
  logic [2:0]       bit_pos;
  logic [9:0]       phase_ticks;
  logic [LINES-1:0] zero_mask;
  logic [LINES-1:0] line_reg;

  logic             sending_next;
  logic [PIX_W-1:0] pixel_pos_next;
  logic [1:0]       byte_pos_next;
  logic [2:0]       bit_pos_next;
  logic [9:0]       phase_ticks_next;
  logic [LINES-1:0] zero_mask_next;
  logic [LINES-1:0] line_reg_next;

  logic [1:0] kind;
  logic [2:0] lane;
  logic [7:0] pixel;
  logic [1:0] byte_sel;
  logic [7:0] data;

  logic                 accept;
  logic                 inval;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [7:0]           rd_data;
  logic [LINES-1:0][7:0] lane_bytes;
  logic                 buf_ready;
  plss_pkg::fetch_ctl_t fctl;
  plss_pkg::res_t       res_next;
  plss_pkg::res_t       out_res;
  plss_pkg::res_t       skid_res;
  logic                 skid_valid;

  logic [3:0]       lanes_eff;
  logic [8:0]       leds_eff;
  logic [2:0]       bpp;
  logic [7:0]       gap;
  logic [9:0]       period;
  logic [9:0]       t_next;
  logic [LINES-1:0] active;
  logic [LINES-1:0] zm_fresh;
  logic [LINES-1:0] zm_use;
  logic [LINES-1:0] lv;

  assign kind     = s_tuser;
  assign lane     = s_tdata[2:0];
  assign pixel    = s_tdata[10:3];
  assign byte_sel = s_tdata[12:11];
  assign data     = s_tdata[20:13];

  assign s_tready = !skid_valid && !(sending && (phase_ticks == '0) && !buf_ready);
  assign accept   = s_tvalid && s_tready;

  // Effective configuration
  assign lanes_eff = ({28'd0, cfg.lane_count} > LINES) ? 4'(LINES) : cfg.lane_count;
  assign leds_eff  = ({23'd0, cfg.led_count} > MAX_PIXELS) ? 9'(MAX_PIXELS) : cfg.led_count;
  assign bpp       = cfg.rgbw_mode ? plss_pkg::BPP_RGBW : plss_pkg::BPP_RGB;
  assign gap       = (cfg.gap_low_ticks == '0) ? 8'd1 : cfg.gap_low_ticks;
  assign period    = {1'b0, cfg.one_high_ticks} + {2'b00, gap};
  assign t_next    = phase_ticks + 10'd1;

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      active[i]   = (i < int'(lanes_eff));
      zm_fresh[i] = active[i] && !lane_bytes[i][~bit_pos];
    end
  end

  assign zm_use = (phase_ticks == '0) ? zm_fresh : zero_mask;

  always_comb begin
    if (phase_ticks < {1'b0, cfg.one_high_ticks}) begin
      lv = (phase_ticks >= {2'b00, cfg.zero_high_ticks}) ? (active & ~zm_use) : active;
    end else begin
      lv = '0;
    end
  end

  always_comb begin
    sending_next     = sending;
    pixel_pos_next   = pixel_pos;
    byte_pos_next    = byte_pos;
    bit_pos_next     = bit_pos;
    phase_ticks_next = phase_ticks;
    zero_mask_next   = zero_mask;
    line_reg_next    = line_reg;
    inval            = cfg_we;
    ram_we           = 1'b0;
    res_next         = '0;
    case (kind)
      plss_pkg::KIND_WRITE: begin
        res_next.write_rejected = sending || ({1'b0, lane} >= lanes_eff) ||
                                  ({1'b0, pixel} >= leds_eff) ||
                                  ({1'b0, byte_sel} >= bpp);
        ram_we = accept && !res_next.write_rejected;
      end
      plss_pkg::KIND_START: begin
        if (!sending && (leds_eff != '0)) begin
          sending_next     = 1'b1;
          pixel_pos_next   = '0;
          byte_pos_next    = '0;
          bit_pos_next     = '0;
          phase_ticks_next = '0;
          zero_mask_next   = '0;
          line_reg_next    = '0;
          inval            = inval || accept;
        end
      end
      plss_pkg::KIND_TICK: begin
        if (sending) begin
          if (phase_ticks == '0) begin
            zero_mask_next = zm_fresh;
          end
          line_reg_next = lv;
          if (t_next < period) begin
            phase_ticks_next = t_next;
          end else begin
            phase_ticks_next = '0;
            if (bit_pos != plss_pkg::BIT_LAST) begin
              bit_pos_next = bit_pos + 3'd1;
            end else begin
              // next byte: refetch the strip bytes
              bit_pos_next = '0;
              inval        = inval || accept;
              if ({1'b0, byte_pos} + 3'd1 < bpp) begin
                byte_pos_next = byte_pos + 2'd1;
              end else begin
                byte_pos_next = '0;
                if (10'(pixel_pos) + 10'd1 < {1'b0, leds_eff}) begin
                  pixel_pos_next = pixel_pos + PIX_W'(1);
                end else begin
                  pixel_pos_next      = '0;
                  sending_next        = 1'b0;
                  res_next.frame_done = 1'b1;
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    res_next.line_levels = 8'(line_reg_next);
    res_next.busy_res    = sending_next;
  end

  assign ram_waddr = ADDR_W'(plss_pkg::store_index({2'b00, lane}, {1'b0, pixel}, byte_sel,
                                                   leds_eff, cfg.rgbw_mode));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lane_count      <= plss_pkg::RST_LANE_COUNT;
      cfg.led_count       <= plss_pkg::RST_LED_COUNT;
      cfg.rgbw_mode       <= plss_pkg::RST_RGBW_MODE;
      cfg.zero_high_ticks <= plss_pkg::RST_ZERO_HIGH;
      cfg.one_high_ticks  <= plss_pkg::RST_ONE_HIGH;
      cfg.gap_low_ticks   <= plss_pkg::RST_GAP_LOW;
    end else if (cfg_we) begin
      case (cfg_index)
        plss_pkg::REG_LANE_COUNT: cfg.lane_count      <= cfg_data[3:0];
        plss_pkg::REG_LED_COUNT:  cfg.led_count       <= cfg_data;
        plss_pkg::REG_RGBW_MODE:  cfg.rgbw_mode       <= cfg_data[0];
        plss_pkg::REG_ZERO_HIGH:  cfg.zero_high_ticks <= cfg_data[7:0];
        plss_pkg::REG_ONE_HIGH:   cfg.one_high_ticks  <= cfg_data;
        plss_pkg::REG_GAP_LOW:    cfg.gap_low_ticks   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending     <= 1'b0;
      pixel_pos   <= '0;
      byte_pos    <= '0;
      bit_pos     <= '0;
      phase_ticks <= '0;
      zero_mask   <= '0;
      line_reg    <= '0;
    end else if (accept) begin
      sending     <= sending_next;
      pixel_pos   <= pixel_pos_next;
      byte_pos    <= byte_pos_next;
      bit_pos     <= bit_pos_next;
      phase_ticks <= phase_ticks_next;
      zero_mask   <= zero_mask_next;
      line_reg    <= line_reg_next;
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      m_tvalid   <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      m_tvalid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (accept) begin
        skid_res <= res_next;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (accept) begin
      out_res <= res_next;
    end
  end

  assign m_tdata = {6'd0, out_res.write_rejected, out_res.busy_res, out_res.line_levels};
  assign m_tlast = out_res.frame_done;

  assign fctl.inval    = inval;
  assign fctl.sending  = sending;
  assign fctl.lanes    = lanes_eff;
  assign fctl.leds     = leds_eff;
  assign fctl.rgbw     = cfg.rgbw_mode;
  assign fctl.pixel    = 9'(pixel_pos);
  assign fctl.byte_pos = byte_pos;

  plss_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  plss_fetch #(
    .LINES  (LINES),
    .ADDR_W (ADDR_W)
  ) u_fetch (
    .clk        (clk),
    .rst        (rst),
    .ctl        (fctl),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .lane_bytes (lane_bytes),
    .ready      (buf_ready)
  );

`ifndef NO_ASSERTIONS
  a_idle_lines_low: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (line_reg == '0))
    else $error("lines not low while idle");

  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !sending)
    else $error("frame store written during refresh");

  a_fetch_in_frame: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> sending)
    else $error("store read outside a refresh");

  a_done_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && res_next.frame_done) |=> !sending)
    else $error("refresh still running after frame done");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held with empty output register");
`endif

endmodule

`default_nettype wire

### bench/parallel_led_strip_serializer_tb.sv
// Self-checking testbench for parallel_led_strip_serializer: predicts every result beat
// from its own model of the frame store and waveform timer. Depends on plss_pkg.
`default_nettype none

module parallel_led_strip_serializer_tb;
  import plss_pkg::*;

  localparam int STRIPS      = LANES_DEF;
  localparam int PIXELS_MAX  = MAX_PIXELS_DEF;
  localparam int STORE_DEPTH = STRIPS * PIXELS_MAX * 4;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // lane[2:0], pixel[10:3], byte_sel[12:11], data[20:13]
  logic [1:0]  s_tuser;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // line_levels[7:0], busy_res[8], write_rejected[9]
  logic        m_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;

  parallel_led_strip_serializer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model state
  logic [7:0]  frame_bytes [0:STORE_DEPTH-1];
  cfg_t        live_cfg;
  logic        tx_on;
  int unsigned tx_pixel;
  int unsigned tx_byte;
  int unsigned tx_bit;
  int unsigned tx_phase;
  logic [7:0]  tx_zero_mask;
  logic [7:0]  tx_lines;

  res_t        expected_results [$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned beat_total;
  logic        beat_counts;
  logic        steady_flow;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned lanes_in_use();
    return (live_cfg.lane_count > STRIPS) ? STRIPS : live_cfg.lane_count;
  endfunction

  function automatic int unsigned pixels_in_use();
    return (live_cfg.led_count > PIXELS_MAX) ? PIXELS_MAX : live_cfg.led_count;
  endfunction

  function automatic int unsigned bytes_per_led();
    return live_cfg.rgbw_mode ? 4 : 3;
  endfunction

  function automatic int unsigned frame_addr(input int unsigned ln, input int unsigned px,
                                             input int unsigned bs);
    return (ln * pixels_in_use() + px) * bytes_per_led() + bs;
  endfunction

  function automatic int unsigned draw_wait();
    return steady_flow ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic void model_reset();
    live_cfg.lane_count      = 4'd1;
    live_cfg.led_count       = 9'd1;
    live_cfg.rgbw_mode       = 1'b0;
    live_cfg.zero_high_ticks = 8'd15;
    live_cfg.one_high_ticks  = 9'd45;
    live_cfg.gap_low_ticks   = 8'd18;
    tx_on        = 1'b0;
    tx_pixel     = 0;
    tx_byte      = 0;
    tx_bit       = 0;
    tx_phase     = 0;
    tx_zero_mask = '0;
    tx_lines     = '0;
  endfunction

  // One waveform tick; returns 1 on the tick that ends the last bit of the frame
  function automatic logic waveform_tick();
    int unsigned lanes;
    int unsigned gap;
    int unsigned period;
    int unsigned t;
    int unsigned i;
    logic [7:0]  level;
    logic [7:0]  active;
    lanes  = lanes_in_use();
    active = 8'((1 << lanes) - 1);
    gap    = (live_cfg.gap_low_ticks == 0) ? 1 : live_cfg.gap_low_ticks;
    period = live_cfg.one_high_ticks + gap;
    t      = tx_phase;
    if (t == 0) begin
      tx_zero_mask = '0;
      for (i = 0; i < lanes; i++) begin
        if (frame_bytes[frame_addr(i, tx_pixel, tx_byte)][7 - tx_bit] == 1'b0)
          tx_zero_mask[i] = 1'b1;
      end
    end
    if (t < live_cfg.one_high_ticks) begin
      level = active;
      if (t >= live_cfg.zero_high_ticks) level &= ~tx_zero_mask;
    end else begin
      level = '0;
    end
    tx_lines = level;
    t++;
    if (t < period) begin
      tx_phase = t & 32'h3FF;
      return 1'b0;
    end
    tx_phase = 0;
    if (tx_bit < 7) begin
      tx_bit++;
      return 1'b0;
    end
    tx_bit = 0;
    if (tx_byte + 1 < bytes_per_led()) begin
      tx_byte++;
      return 1'b0;
    end
    tx_byte = 0;
    if (tx_pixel + 1 < pixels_in_use()) begin
      tx_pixel++;
      return 1'b0;
    end
    tx_pixel = 0;
    tx_on    = 1'b0;
    return 1'b1;
  endfunction

  function automatic res_t predict_beat(input logic [1:0] kind, input logic [2:0] lane,
                                        input logic [7:0] pixel, input logic [1:0] bsel,
                                        input logic [7:0] data);
    res_t r;
    r = '0;
    beat_counts = 1'b0;
    case (kind)
      KIND_WRITE: begin
        if (tx_on || lane >= lanes_in_use() || pixel >= pixels_in_use() ||
            bsel >= bytes_per_led()) begin
          r.write_rejected = 1'b1;
        end else begin
          frame_bytes[frame_addr(lane, pixel, bsel)] = data;
          beat_counts = 1'b1;
        end
      end
      KIND_START: begin
        if (!tx_on && pixels_in_use() > 0) begin
          tx_on        = 1'b1;
          tx_pixel     = 0;
          tx_byte      = 0;
          tx_bit       = 0;
          tx_phase     = 0;
          tx_zero_mask = '0;
          tx_lines     = '0;
          beat_counts  = 1'b1;
        end
      end
      KIND_TICK: begin
        if (tx_on) begin
          r.frame_done = waveform_tick();
          beat_counts  = 1'b1;
        end
      end
      default: ;
    endcase
    r.line_levels = tx_lines;
    r.busy_res    = tx_on;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("result %0d: %s got 0x%0h, want 0x%0h", result_count, what, got, want);
  endtask

  // Result side: check each beat against the oldest prediction, then stall at random
  initial begin : result_monitor
    res_t        seen;
    res_t        want;
    int unsigned stall;
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        seen.line_levels    = m_tdata[7:0];
        seen.busy_res       = m_tdata[8];
        seen.write_rejected = m_tdata[9];
        seen.frame_done     = m_tlast;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat, line_levels", seen.line_levels, 0);
        end else begin
          want = expected_results.pop_front();
          if (seen.line_levels !== want.line_levels)
            report_mismatch("line_levels", seen.line_levels, want.line_levels);
          if (seen.busy_res !== want.busy_res)
            report_mismatch("busy_res", seen.busy_res, want.busy_res);
          if (seen.frame_done !== want.frame_done)
            report_mismatch("frame_done", seen.frame_done, want.frame_done);
          if (seen.write_rejected !== want.write_rejected)
            report_mismatch("write_rejected", seen.write_rejected, want.write_rejected);
        end
        result_count++;
        stall = draw_wait();
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Leaves s_tvalid high after acceptance; whoever idles the input next lowers it
  task automatic send_beat(input logic [1:0] kind, input logic [2:0] lane,
                           input logic [7:0] pixel, input logic [1:0] bsel,
                           input logic [7:0] data);
    int unsigned gap;
    res_t        r;
    gap = draw_wait();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = predict_beat(kind, lane, pixel, bsel, data);
    expected_results.push_back(r);
    if (beat_counts) beat_total++;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, data, bsel, pixel, lane};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_beat(KIND_TICK, 3'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [8:0] value);
    s_tvalid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_LANE_COUNT: live_cfg.lane_count      = value[3:0];
      REG_LED_COUNT:  live_cfg.led_count       = value[8:0];
      REG_RGBW_MODE:  live_cfg.rgbw_mode       = value[0];
      REG_ZERO_HIGH:  live_cfg.zero_high_ticks = value[7:0];
      REG_ONE_HIGH:   live_cfg.one_high_ticks  = value[8:0];
      REG_GAP_LOW:    live_cfg.gap_low_ticks   = value[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [3:0] lanes, input logic [8:0] leds,
                              input logic rgbw, input logic [7:0] zero_hi,
                              input logic [8:0] one_hi, input logic [7:0] gap_lo);
    wait_results();
    write_reg(REG_LANE_COUNT, 9'(lanes));
    write_reg(REG_LED_COUNT, leds);
    write_reg(REG_RGBW_MODE, 9'(rgbw));
    write_reg(REG_ZERO_HIGH, 9'(zero_hi));
    write_reg(REG_ONE_HIGH, one_hi);
    write_reg(REG_GAP_LOW, 9'(gap_lo));
  endtask

  // Random junk; a start only while a refresh may already run
  task automatic send_noise(input logic allow_start);
    case ($urandom_range(0, allow_start ? 3 : 2))
      0: send_beat(KIND_WRITE, 3'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
      1: send_tick();
      2: send_beat(KIND_UNUSED, 3'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
      default: send_beat(KIND_START, 3'($urandom), 8'($urandom), 2'($urandom),
                         8'($urandom));
    endcase
  endtask

  // Write every byte the current layout will read during a refresh
  task automatic fill_frame(input int unsigned noise_pct);
    int unsigned ln;
    int unsigned px;
    int unsigned bs;
    logic [7:0]  value;
    for (ln = 0; ln < lanes_in_use(); ln++) begin
      for (px = 0; px < pixels_in_use(); px++) begin
        for (bs = 0; bs < bytes_per_led(); bs++) begin
          if ($urandom_range(0, 99) < noise_pct) send_noise(1'b0);
          case ($urandom_range(0, 7))
            0:       value = 8'h00;
            1:       value = 8'hFF;
            default: value = 8'($urandom);
          endcase
          send_beat(KIND_WRITE, 3'(ln), 8'(px), 2'(bs), value);
        end
      end
    end
  endtask

  // Drain, then retime and shrink the layout so every read stays inside the filled bytes
  task automatic shrink_mid_frame();
    wait_results();
    write_reg(REG_ZERO_HIGH, 9'($urandom_range(0, 6)));
    write_reg(REG_ONE_HIGH, 9'($urandom_range(1, 8)));
    write_reg(REG_GAP_LOW, 9'($urandom_range(0, 3)));
    write_reg(REG_LANE_COUNT, 9'($urandom_range(0, lanes_in_use())));
    write_reg(REG_LED_COUNT, 9'($urandom_range(0, pixels_in_use())));
    if (live_cfg.rgbw_mode && $urandom_range(0, 1) == 0) write_reg(REG_RGBW_MODE, 9'(0));
  endtask

  task automatic tick_to_end(input int unsigned noise_pct, input logic allow_change);
    int unsigned change_at;
    int unsigned n;
    change_at = allow_change ? $urandom_range(1, 80) : 0;
    n = 0;
    while (tx_on) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise(1'b1);
      else send_tick();
      n++;
      if (n == change_at) shrink_mid_frame();
      else if ($urandom_range(0, 299) == 0) wait_results();
    end
  endtask

  // Reset values, idle ticks, bad writes and junk during a refresh
  task automatic test_defaults_frame();
    send_tick();
    send_beat(KIND_UNUSED, 3'd0, 8'd0, 2'd0, 8'd0);
    send_beat(KIND_WRITE, 3'd0, 8'd0, 2'd0, 8'hFF);
    send_beat(KIND_WRITE, 3'd0, 8'd0, 2'd1, 8'h00);
    send_beat(KIND_WRITE, 3'd0, 8'd0, 2'd2, 8'hA5);
    send_beat(KIND_WRITE, 3'd7, 8'd0, 2'd0, 8'h11);
    send_beat(KIND_WRITE, 3'd0, 8'd255, 2'd0, 8'h22);
    send_beat(KIND_WRITE, 3'd0, 8'd0, 2'd3, 8'h33);
    send_beat(KIND_START, 3'd0, 8'd0, 2'd0, 8'd0);
    send_beat(KIND_START, 3'd0, 8'd0, 2'd0, 8'd0);
    send_beat(KIND_WRITE, 3'd0, 8'd0, 2'd0, 8'h5A);
    send_beat(KIND_UNUSED, 3'd7, 8'd255, 2'd3, 8'hFF);
    tick_to_end(0, 1'b0);
  endtask

  // Zero high past one high, zero gap, then a short bit of one high 2 and gap 1
  task automatic test_timing_corners();
    apply_config(4'd8, 9'd1, 1'b1, 8'd5, 9'd3, 8'd0);
    fill_frame(0);
    send_beat(KIND_START, 3'd0, 8'd0, 2'd0, 8'd0);
    tick_to_end(0, 1'b0);
    apply_config(4'd8, 9'd1, 1'b1, 8'd1, 9'd2, 8'd1);
    send_beat(KIND_START, 3'd0, 8'd0, 2'd0, 8'd0);
    tick_to_end(0, 1'b0);
  endtask

  task automatic test_lane_overflow();
    apply_config(4'd15, 9'd1, 1'b0, 8'd2, 9'd4, 8'd2);
    fill_frame(0);
    send_beat(KIND_WRITE, 3'd7, 8'd0, 2'd2, 8'h81);
    send_beat(KIND_START, 3'd0, 8'd0, 2'd0, 8'd0);
    tick_to_end(0, 1'b0);
  endtask

  // Shrink the frame under the running position, with the slowest timing for a while
  task automatic test_change_mid_frame();
    apply_config(4'd2, 9'd3, 1'b1, 8'd1, 9'd3, 8'd1);
    fill_frame(0);
    send_beat(KIND_START, 3'd0, 8'd0, 2'd0, 8'd0);
    while (tx_pixel != 2) send_tick();
    wait_results();
    write_reg(REG_LED_COUNT, 9'd1);
    write_reg(REG_ZERO_HIGH, 9'd255);
    write_reg(REG_ONE_HIGH, 9'd511);
    write_reg(REG_GAP_LOW, 9'd255);
    repeat (800) send_tick();
    wait_results();
    write_reg(REG_ZERO_HIGH, 9'd1);
    write_reg(REG_ONE_HIGH, 9'd2);
    write_reg(REG_GAP_LOW, 9'd1);
    write_reg(REG_RGBW_MODE, 9'd0);
    tick_to_end(0, 1'b0);
  endtask

  // Last pixel write, empty frame, then a full-length frame with no lanes
  task automatic test_long_dark_frame();
    apply_config(4'd1, 9'd256, 1'b0, 8'd1, 9'd2, 8'd1);
    send_beat(KIND_WRITE, 3'd0, 8'd255, 2'd2, 8'h3C);
    wait_results();
    write_reg(REG_LED_COUNT, 9'd0);
    send_beat(KIND_START, 3'd0, 8'd0, 2'd0, 8'd0);
    send_beat(KIND_WRITE, 3'd0, 8'd0, 2'd0, 8'h77);
    send_tick();
    wait_results();
    write_reg(REG_LANE_COUNT, 9'd0);
    write_reg(REG_LED_COUNT, 9'd511);
    send_beat(KIND_WRITE, 3'd0, 8'd0, 2'd0, 8'h77);
    steady_flow = 1'b1;
    send_beat(KIND_START, 3'd0, 8'd0, 2'd0, 8'd0);
    tick_to_end(0, 1'b0);
    steady_flow = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned goal;
    int unsigned pick;
    logic [3:0]  lanes;
    logic [8:0]  leds;
    goal = beat_total + 1800;
    while (beat_total < goal) begin
      steady_flow = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) lanes = 4'd0;
      else if (pick == 9) lanes = 4'($urandom_range(9, 15));
      else lanes = 4'(pick);
      pick = $urandom_range(0, 9);
      if (pick == 0) leds = 9'd0;
      else if (pick == 9) leds = 9'($urandom_range(3, 6));
      else leds = 9'($urandom_range(1, 2));
      apply_config(lanes, leds, 1'($urandom), 8'($urandom_range(0, 6)),
                   9'($urandom_range(0, 7)), 8'($urandom_range(0, 3)));
      fill_frame(15);
      send_beat(KIND_START, 3'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
      tick_to_end(10, $urandom_range(0, 3) == 0);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    rst         <= 1'b1;
    mismatch_count = 0;
    result_count   = 0;
    beat_total     = 0;
    beat_counts    = 1'b0;
    steady_flow    = 1'b0;
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults_frame();
    test_timing_corners();
    test_lane_overflow();
    test_change_mid_frame();
    test_long_dark_frame();
    test_random_frames();
    wait_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
